@@ rtl/core/dple_pkg.sv @@
// dple_pkg: shared types, byte codes and decimal step table for the drat proof line encoder
// no dependencies; used by dple_front, dple_queue, dple_back and the encoder top

package dple_pkg;

   localparam int MAX_VARS    = 4096;
   localparam int VAR_W       = 12;
   localparam int MAP_W       = 30;
   localparam int ADDR_W      = $clog2(MAX_VARS);
   localparam int VAL_W       = MAP_W + 1;
   localparam int DIGIT_N     = 10;
   localparam int DIG_IDX_W   = $clog2(DIGIT_N);
   localparam int STEP_W      = 34;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_MAP   = 2'd0,
      CMD_LIT   = 2'd1,
      CMD_EMPTY = 2'd2
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PRE_A,
      ST_PRE_D,
      ST_PRE_SP,
      ST_MINUS,
      ST_DIGIT,
      ST_SPACE,
      ST_ZERO,
      ST_NEWLINE,
      ST_VARINT,
      ST_NUL
   } state_type;

   typedef struct packed {
      logic             is_empty;
      logic             negated;
      logic             first;
      logic             last;
      logic             delete_line;
      logic [MAP_W-1:0] mapped;
   } job_type;

   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NL    = 8'h0a;
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam int         GROUP_W  = 7;

   // multiples m * 10^k, one row per decimal position
   typedef logic [9:1][STEP_W-1:0] step_row_type;
   typedef step_row_type [DIGIT_N-1:0] step_table_type;

   function automatic step_table_type build_steps();
      step_table_type    t;
      logic [STEP_W-1:0] p;
      p = STEP_W'(1);
      for (int k = 0; k < DIGIT_N; k++) begin
         for (int m = 1; m <= 9; m++) begin
            t[k][m] = STEP_W'(m) * p;
         end
         p = p * STEP_W'(10);
      end
      return t;
   endfunction

   localparam step_table_type STEP_TABLE = build_steps();

endpackage

@@ rtl/core/dple_ram.sv @@
// dple_ram: generic single write port, single read port ram with registered read
// no dependencies

module dple_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/dple_front.sv @@
// dple_front: accepts requests, writes map entries, looks up literals and forms jobs
// depends on dple_pkg; drives the map ram and the job queue

module dple_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_cmd,
   input  logic [dple_pkg::VAR_W-1:0]   req_var_index,
   input  logic                         req_negated,
   input  logic                         req_first,
   input  logic                         req_last,
   input  logic                         req_delete_line,
   input  logic [dple_pkg::MAP_W-1:0]   req_map_value,
   input  logic                         q_full,
   output logic                         q_push,
   output dple_pkg::job_type            q_job,
   output logic                         ram_wr_en,
   output logic [dple_pkg::ADDR_W-1:0]  ram_wr_addr,
   output logic [dple_pkg::MAP_W-1:0]   ram_wr_data,
   output logic                         ram_rd_en,
   output logic [dple_pkg::ADDR_W-1:0]  ram_rd_addr,
   input  logic [dple_pkg::MAP_W-1:0]   ram_rd_data
);

   logic accept;
   logic in_range;
   logic s1_load;
   logic s1_valid_ff, s1_valid_in;
   logic s1_empty_ff, s1_neg_ff, s1_first_ff, s1_last_ff, s1_del_ff, s1_hit_ff;

   assign accept   = req_valid && !req_stall;
   assign in_range = {1'b0, req_var_index} < (dple_pkg::VAR_W + 1)'(dple_pkg::MAX_VARS);

   // the lookup data waits in the ram read register while the queue is full
   assign req_stall = s1_valid_ff && q_full;

   assign ram_wr_en   = accept && (req_cmd == dple_pkg::CMD_MAP) && in_range;
   assign ram_wr_addr = req_var_index[dple_pkg::ADDR_W-1:0];
   assign ram_wr_data = req_map_value;
   assign ram_rd_en   = accept && (req_cmd == dple_pkg::CMD_LIT);
   assign ram_rd_addr = req_var_index[dple_pkg::ADDR_W-1:0];

   assign s1_load = accept && ((req_cmd == dple_pkg::CMD_LIT) || (req_cmd == dple_pkg::CMD_EMPTY));
   assign q_push  = s1_valid_ff && !q_full;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (q_push) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      q_job.is_empty    = s1_empty_ff;
      q_job.negated     = s1_neg_ff;
      q_job.first       = s1_first_ff;
      q_job.last        = s1_last_ff;
      q_job.delete_line = s1_del_ff;
      q_job.mapped      = (s1_hit_ff && !s1_empty_ff) ? ram_rd_data : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_empty_ff <= (req_cmd == dple_pkg::CMD_EMPTY);
         s1_neg_ff   <= req_negated;
         s1_first_ff <= req_first;
         s1_last_ff  <= req_last;
         s1_del_ff   <= req_delete_line;
         s1_hit_ff   <= in_range;
      end
   end

endmodule

@@ rtl/core/dple_queue.sv @@
// dple_queue: short job queue between the request front and the byte sequencer
// depends on dple_pkg for the job type and depth

module dple_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dple_pkg::job_type push_job,
   input  logic              pop,
   output dple_pkg::job_type head,
   output logic              full,
   output logic              empty
);

   dple_pkg::job_type                 mem_ff [dple_pkg::QUEUE_DEPTH];
   logic [dple_pkg::QPTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [dple_pkg::QCNT_W-1:0]       count_ff, count_in;

   assign full  = (count_ff == dple_pkg::QCNT_W'(dple_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == dple_pkg::QPTR_W'(dple_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == dple_pkg::QPTR_W'(dple_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ rtl/core/dple_back.sv @@
// dple_back: byte sequencer, turns one job into proof bytes, one byte per unstalled cycle
// depends on dple_pkg; pops jobs from dple_queue and drives the response register

module dple_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              text_mode,
   input  logic              q_empty,
   input  dple_pkg::job_type q_head,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_end_of_run
);

   dple_pkg::state_type state_ff, state_in, next_c, start_c, dstart_c;

   logic [dple_pkg::VAL_W-1:0]     val_ff, val_in, val_step;
   logic [dple_pkg::DIG_IDX_W-1:0] k_ff, k_in, k_step, k_start;
   logic                           neg_ff, last_ff, empty_ff, text_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [7:0]                     byte_ff, byte_in, byte_c;
   logic                           end_ff, end_in;
   logic                           out_free;
   logic                           more;
   logic [dple_pkg::STEP_W-1:0]    dig_sel;
   logic [3:0]                     dig_val;
   logic [dple_pkg::STEP_W-1:0]    val_wide, head_wide;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign q_pop    = (state_ff == dple_pkg::ST_IDLE) && !q_empty;

   assign val_wide  = {(dple_pkg::STEP_W - dple_pkg::MAP_W)'(0), val_ff[dple_pkg::MAP_W-1:0]};
   assign head_wide = {(dple_pkg::STEP_W - dple_pkg::MAP_W)'(0), q_head.mapped};
   assign more      = |val_ff[dple_pkg::VAL_W-1:dple_pkg::GROUP_W];
   assign dstart_c  = (val_ff[dple_pkg::MAP_W-1:0] == '0) ? dple_pkg::ST_SPACE :
                                                            dple_pkg::ST_DIGIT;

   // one decimal digit per step: largest multiple of the current power not above the value
   always_comb begin
      dig_sel = '0;
      dig_val = '0;
      for (int m = 1; m <= 9; m++) begin
         if (val_wide >= dple_pkg::STEP_TABLE[k_ff][m]) begin
            dig_sel = dple_pkg::STEP_TABLE[k_ff][m];
            dig_val = 4'(m);
         end
      end
   end

   // position of the leading digit, so leading zeros are never sent
   always_comb begin
      k_start = '0;
      for (int j = 1; j < dple_pkg::DIGIT_N; j++) begin
         if (head_wide >= dple_pkg::STEP_TABLE[j][1]) begin
            k_start = dple_pkg::DIG_IDX_W'(j);
         end
      end
   end

   always_comb begin
      start_c = dple_pkg::ST_VARINT;
      if (q_head.is_empty) begin
         start_c = text_mode ? dple_pkg::ST_ZERO : dple_pkg::ST_PRE_A;
      end else if (q_head.first && q_head.delete_line) begin
         start_c = dple_pkg::ST_PRE_D;
      end else if (q_head.first && !text_mode) begin
         start_c = dple_pkg::ST_PRE_A;
      end else if (text_mode) begin
         if (q_head.negated) begin
            start_c = dple_pkg::ST_MINUS;
         end else if (q_head.mapped == '0) begin
            start_c = dple_pkg::ST_SPACE;
         end else begin
            start_c = dple_pkg::ST_DIGIT;
         end
      end
   end

   always_comb begin
      byte_c   = dple_pkg::CH_NUL;
      next_c   = dple_pkg::ST_IDLE;
      val_step = val_ff;
      k_step   = k_ff;
      unique case (state_ff)
         dple_pkg::ST_IDLE: begin
            next_c = dple_pkg::ST_IDLE;
         end
         dple_pkg::ST_PRE_A: begin
            byte_c = dple_pkg::CH_A;
            next_c = empty_ff ? dple_pkg::ST_NUL : dple_pkg::ST_VARINT;
         end
         dple_pkg::ST_PRE_D: begin
            byte_c = dple_pkg::CH_D;
            next_c = text_ff ? dple_pkg::ST_PRE_SP : dple_pkg::ST_VARINT;
         end
         dple_pkg::ST_PRE_SP: begin
            byte_c = dple_pkg::CH_SP;
            next_c = neg_ff ? dple_pkg::ST_MINUS : dstart_c;
         end
         dple_pkg::ST_MINUS: begin
            byte_c = dple_pkg::CH_MINUS;
            next_c = dstart_c;
         end
         dple_pkg::ST_DIGIT: begin
            byte_c   = dple_pkg::CH_ZERO + {4'b0, dig_val};
            next_c   = (k_ff == '0) ? dple_pkg::ST_SPACE : dple_pkg::ST_DIGIT;
            val_step = val_ff - {1'b0, dig_sel[dple_pkg::MAP_W-1:0]};
            k_step   = k_ff - 1'b1;
         end
         dple_pkg::ST_SPACE: begin
            byte_c = dple_pkg::CH_SP;
            next_c = last_ff ? dple_pkg::ST_ZERO : dple_pkg::ST_IDLE;
         end
         dple_pkg::ST_ZERO: begin
            byte_c = dple_pkg::CH_ZERO;
            next_c = empty_ff ? dple_pkg::ST_IDLE : dple_pkg::ST_NEWLINE;
         end
         dple_pkg::ST_NEWLINE: begin
            byte_c = dple_pkg::CH_NL;
            next_c = dple_pkg::ST_IDLE;
         end
         dple_pkg::ST_VARINT: begin
            byte_c   = {more, val_ff[dple_pkg::GROUP_W-1:0]};
            next_c   = more ? dple_pkg::ST_VARINT :
                       (last_ff ? dple_pkg::ST_NUL : dple_pkg::ST_IDLE);
            val_step = val_ff >> dple_pkg::GROUP_W;
         end
         dple_pkg::ST_NUL: begin
            byte_c = dple_pkg::CH_NUL;
            next_c = dple_pkg::ST_IDLE;
         end
         default: begin
            next_c = dple_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      val_in       = val_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      byte_in      = byte_ff;
      end_in       = end_ff;
      if (q_pop) begin
         state_in = start_c;
         val_in   = text_mode ? {1'b0, q_head.mapped} : {q_head.mapped, q_head.negated};
         k_in     = k_start;
      end else if ((state_ff != dple_pkg::ST_IDLE) && out_free) begin
         state_in     = next_c;
         val_in       = val_step;
         k_in         = k_step;
         rsp_valid_in = 1'b1;
         byte_in      = byte_c;
         end_in       = (next_c == dple_pkg::ST_IDLE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dple_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      k_ff    <= k_in;
      byte_ff <= byte_in;
      end_ff  <= end_in;
      if (q_pop) begin
         neg_ff   <= q_head.negated;
         last_ff  <= q_head.last;
         empty_ff <= q_head.is_empty;
         text_ff  <= text_mode;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_end_of_run = end_ff;

endmodule

@@ rtl/core/drat_proof_line_encoder_top.sv @@
// drat proof line encoder: requests in, proof bytes out, one byte per response; depends on
//   dple_pkg, dple_ram, dple_front, dple_queue and dple_back
// path: a request passes the map ram read register, the job queue and the sequencer state
//   before its first byte is registered in the response register
// throughput: one byte per cycle while rsp_stall is low, and none while a job loads
// reset: synchronous, active high; clears control state and text_mode, not the variable map

module drat_proof_line_encoder_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_cmd,
   input  logic [dple_pkg::VAR_W-1:0]  req_var_index,
   input  logic                        req_negated,
   input  logic                        req_first,
   input  logic                        req_last,
   input  logic                        req_delete_line,
   input  logic [dple_pkg::MAP_W-1:0]  req_map_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_end_of_run,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_text_mode
);

   logic                           text_mode_ff;
   logic                           q_full, q_empty, q_push, q_pop;
   dple_pkg::job_type              push_job, head_job;
   logic                           ram_wr_en, ram_rd_en;
   logic [dple_pkg::ADDR_W-1:0]    ram_wr_addr, ram_rd_addr;
   logic [dple_pkg::MAP_W-1:0]     ram_wr_data, ram_rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         text_mode_ff <= csr_text_mode;
      end
   end

   dple_ram #(
      .WIDTH (dple_pkg::MAP_W),
      .DEPTH (dple_pkg::MAX_VARS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   dple_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_var_index   (req_var_index),
      .req_negated     (req_negated),
      .req_first       (req_first),
      .req_last        (req_last),
      .req_delete_line (req_delete_line),
      .req_map_value   (req_map_value),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_job           (push_job),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_en       (ram_rd_en),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data)
   );

   dple_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head     (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   dple_back u_back (
      .clock          (clock),
      .reset          (reset),
      .text_mode      (text_mode_ff),
      .q_empty        (q_empty),
      .q_head         (head_job),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_end_of_run (rsp_end_of_run)
   );

endmodule

@@ rtl/core/dple_checker.sv @@
// dple_checker: port level checks on the response channel of the encoder top
// depends on nothing but the top level ports; bound to drat_proof_line_encoder_top

module dple_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_end_of_run
);

   // a stalled response stays and keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_end_of_run))
      else $error("stalled response changed");

   // reset leaves no response pending
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a varint byte with the continuation bit is never the last byte of a request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_byte[7] |-> !rsp_end_of_run)
      else $error("continuation byte closes a run");

endmodule

bind drat_proof_line_encoder_top dple_checker u_checker (.*);

@@ verif/tb.sv @@
// tb: self-checking bench for drat_proof_line_encoder_top, binary and text proof lines
// predicts every proof byte from its own variable map copy; needs dple_pkg and the rtl

`timescale 1ns / 100ps

module tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_TICKS = 32;
   localparam int BURST_MAX    = 16;
   localparam int IDLE_PCT     = 14;
   localparam logic [1:0] CMD_NOP = 2'd3;
   localparam logic [dple_pkg::MAP_W-1:0] MAP_TOP = '1;

   typedef struct {
      logic [1:0]                 cmd;
      logic [dple_pkg::VAR_W-1:0] idx;
      logic                       neg;
      logic                       first;
      logic                       last;
      logic                       del;
      logic [dple_pkg::MAP_W-1:0] mval;
   } proof_req_type;

   typedef struct {
      logic [7:0] data;
      logic       eor;
   } proof_byte_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic rsp_valid;
   logic rsp_stall;
   logic [7:0] rsp_out_byte;
   logic rsp_end_of_run;
   logic csr_valid;
   logic csr_ready;
   logic csr_text_mode;
   proof_req_type cur_req;

   proof_req_type  pending_reqs[$];
   proof_byte_type expected_bytes[$];
   proof_byte_type want;

   // predictor state
   logic [dple_pkg::MAP_W-1:0] var_map[dple_pkg::MAX_VARS];
   logic                       text_lines;

   // stimulus-side record of written map entries
   bit                         gen_written[dple_pkg::MAX_VARS];
   logic [dple_pkg::VAR_W-1:0] gen_known[$];

   bit req_taken;
   int idle_pct;
   int err_count;
   int cycle_count;
   int n_lit, n_map, n_empty, n_nop, n_bytes, n_mode;

   drat_proof_line_encoder_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (cur_req.cmd),
      .req_var_index   (cur_req.idx),
      .req_negated     (cur_req.neg),
      .req_first       (cur_req.first),
      .req_last        (cur_req.last),
      .req_delete_line (cur_req.del),
      .req_map_value   (cur_req.mval),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_end_of_run  (rsp_end_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_text_mode   (csr_text_mode)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      err_count++;
   endtask

   function automatic bit take_break();
      return $urandom_range(0, 99) < idle_pct;
   endfunction

   function automatic bit rand_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   // expected proof bytes for one accepted request
   task automatic encode_request(input proof_req_type r);
      logic [7:0]                 run[$];
      logic [7:0]                 digs[$];
      logic [dple_pkg::MAP_W-1:0] mapped;
      logic [dple_pkg::MAP_W:0]   word;
      proof_byte_type             pb;
      int                         cnt;
      unique case (r.cmd)
         dple_pkg::CMD_MAP: begin
            var_map[r.idx] = r.mval;
            n_map++;
         end
         dple_pkg::CMD_EMPTY: begin
            n_empty++;
            if (text_lines) begin
               run.push_back(dple_pkg::CH_ZERO);
            end else begin
               run.push_back(dple_pkg::CH_A);
               run.push_back(dple_pkg::CH_NUL);
            end
         end
         dple_pkg::CMD_LIT: begin
            n_lit++;
            mapped = var_map[r.idx];
            if (r.first) begin
               if (r.del) begin
                  run.push_back(dple_pkg::CH_D);
                  if (text_lines) run.push_back(dple_pkg::CH_SP);
               end else if (!text_lines) begin
                  run.push_back(dple_pkg::CH_A);
               end
            end
            if (text_lines) begin
               if (r.neg) run.push_back(dple_pkg::CH_MINUS);
               while (mapped != 0) begin
                  digs.push_front(dple_pkg::CH_ZERO + 8'(mapped % 10));
                  mapped = dple_pkg::MAP_W'(mapped / 10);
               end
               run = {run, digs};
               run.push_back(dple_pkg::CH_SP);
               if (r.last) begin
                  run.push_back(dple_pkg::CH_ZERO);
                  run.push_back(dple_pkg::CH_NL);
               end
            end else begin
               word = {mapped, r.neg};
               while (word > 127) begin
                  run.push_back({1'b1, word[6:0]});
                  word = word >> 7;
               end
               run.push_back(word[7:0]);
               if (r.last) run.push_back(dple_pkg::CH_NUL);
            end
         end
         default: n_nop++;
      endcase
      cnt = (run.size() > BURST_MAX) ? BURST_MAX : run.size();
      for (int i = 0; i < cnt; i++) begin
         pb.data = run[i];
         pb.eor  = (i == cnt - 1);
         expected_bytes.push_back(pb);
      end
   endtask

   // monitor: requests accepted and bytes returned, both at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            encode_request(cur_req);
         end
         if (rsp_valid && !rsp_stall) begin
            n_bytes++;
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("byte %h with nothing expected", rsp_out_byte));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.data)
                  report_mismatch($sformatf("out_byte %h, expected %h",
                                            rsp_out_byte, want.data));
               if (rsp_end_of_run !== want.eor)
                  report_mismatch($sformatf("end_of_run %b, expected %b on byte %h",
                                            rsp_end_of_run, want.eor, want.data));
            end
         end
      end
   end

   // driver: new request or stall level at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= take_break();
         if (!req_valid || req_taken) begin
            if (pending_reqs.size() != 0 && !take_break()) begin
               cur_req   <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         req_taken = 1'b0;
      end
   end

   function automatic proof_req_type make_req(input logic [1:0] cmd, input int idx,
                                              input bit neg, input bit first, input bit last,
                                              input bit del,
                                              input logic [dple_pkg::MAP_W-1:0] mval);
      proof_req_type r;
      r.cmd   = cmd;
      r.idx   = dple_pkg::VAR_W'(idx);
      r.neg   = neg;
      r.first = first;
      r.last  = last;
      r.del   = del;
      r.mval  = mval;
      return r;
   endfunction

   function automatic logic [dple_pkg::MAP_W-1:0] rand_map_value();
      logic [dple_pkg::MAP_W-1:0] v;
      v = dple_pkg::MAP_W'($urandom_range(1, MAP_TOP)) >> $urandom_range(0, dple_pkg::MAP_W - 1);
      if ($urandom_range(0, 19) == 0) v = MAP_TOP;
      return (v == 0) ? dple_pkg::MAP_W'(1) : v;
   endfunction

   task automatic queue_map_write(input int idx, input logic [dple_pkg::MAP_W-1:0] val);
      pending_reqs.push_back(make_req(dple_pkg::CMD_MAP, idx, rand_bit(), rand_bit(),
                                      rand_bit(), rand_bit(), val));
      if (!gen_written[idx]) begin
         gen_written[idx] = 1'b1;
         gen_known.push_back(dple_pkg::VAR_W'(idx));
      end
   endtask

   function automatic int pick_known();
      return int'(gen_known[$urandom_range(0, gen_known.size() - 1)]);
   endfunction

   // mostly well-formed lines with random content, some noise and broken lines
   task automatic queue_random(input int count);
      int made, len, pick;
      bit del;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(0, 99);
         if (gen_known.size() < 8 || pick < 12) begin
            queue_map_write($urandom_range(0, dple_pkg::MAX_VARS - 1), rand_map_value());
            made++;
         end else if (pick < 80) begin
            len = $urandom_range(1, 5);
            del = rand_bit();
            for (int i = 0; i < len; i++)
               pending_reqs.push_back(make_req(dple_pkg::CMD_LIT, pick_known(), rand_bit(),
                                               i == 0, i == len - 1, del,
                                               dple_pkg::MAP_W'($urandom())));
            made += len;
         end else if (pick < 88) begin
            pending_reqs.push_back(make_req(dple_pkg::CMD_EMPTY,
                                            $urandom_range(0, dple_pkg::MAX_VARS - 1),
                                            rand_bit(), rand_bit(), rand_bit(), rand_bit(),
                                            dple_pkg::MAP_W'($urandom())));
            made++;
         end else if (pick < 94) begin
            pending_reqs.push_back(make_req(dple_pkg::CMD_LIT, pick_known(), rand_bit(),
                                            rand_bit(), rand_bit(), rand_bit(),
                                            dple_pkg::MAP_W'($urandom())));
            made++;
         end else begin
            // ignored command, not counted
            pending_reqs.push_back(make_req(CMD_NOP, $urandom_range(0, dple_pkg::MAX_VARS - 1),
                                            rand_bit(), rand_bit(), rand_bit(), rand_bit(),
                                            dple_pkg::MAP_W'($urandom())));
         end
      end
   endtask

   task automatic wait_quiet();
      @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_bytes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_mode(input bit mode);
      @(negedge clock);
      csr_valid     <= 1'b1;
      csr_text_mode <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      text_lines = mode;
      n_mode++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run stalled after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      rsp_stall     = 1'b0;
      csr_valid     = 1'b0;
      csr_text_mode = 1'b0;
      cur_req       = make_req(CMD_NOP, 0, 0, 0, 0, 0, '0);
      req_taken     = 1'b0;
      text_lines    = 1'b0;
      idle_pct      = IDLE_PCT;
      err_count     = 0;
      foreach (var_map[i]) var_map[i] = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // binary lines after reset: map extremes and varint group boundaries
      queue_map_write(0, dple_pkg::MAP_W'(1));
      queue_map_write(dple_pkg::MAX_VARS - 1, MAP_TOP);
      queue_map_write(1, dple_pkg::MAP_W'(127));
      queue_map_write(2, dple_pkg::MAP_W'(63));
      queue_map_write(3, dple_pkg::MAP_W'(64));
      pending_reqs.push_back(make_req(dple_pkg::CMD_LIT, 0, 0, 1, 1, 0, '0));
      pending_reqs.push_back(make_req(dple_pkg::CMD_LIT, dple_pkg::MAX_VARS - 1, 1, 1, 0, 1,
                                      MAP_TOP));
      pending_reqs.push_back(make_req(dple_pkg::CMD_LIT, 1, 1, 0, 0, 1, '0));
      pending_reqs.push_back(make_req(dple_pkg::CMD_LIT, 2, 1, 0, 0, 0, '0));
      pending_reqs.push_back(make_req(dple_pkg::CMD_LIT, 3, 0, 0, 1, 1, '0));
      pending_reqs.push_back(make_req(dple_pkg::CMD_EMPTY, dple_pkg::MAX_VARS - 1, 1, 1, 1, 1,
                                      MAP_TOP));
      pending_reqs.push_back(make_req(CMD_NOP, dple_pkg::MAX_VARS - 1, 1, 1, 1, 1, MAP_TOP));
      queue_random(80);
      wait_quiet();

      // text lines: longest line, no prefix on add, lone zero for the empty clause
      write_mode(1'b1);
      pending_reqs.push_back(make_req(dple_pkg::CMD_LIT, dple_pkg::MAX_VARS - 1, 1, 1, 1, 1,
                                      '0));
      pending_reqs.push_back(make_req(dple_pkg::CMD_LIT, 0, 0, 1, 0, 0, '0));
      pending_reqs.push_back(make_req(dple_pkg::CMD_LIT, 1, 1, 0, 0, 0, '0));
      pending_reqs.push_back(make_req(dple_pkg::CMD_LIT, 3, 0, 0, 1, 1, '0));
      pending_reqs.push_back(make_req(dple_pkg::CMD_EMPTY, 0, 0, 0, 0, 0, '0));
      pending_reqs.push_back(make_req(CMD_NOP, 0, 0, 0, 0, 0, '0));
      queue_random(80);
      wait_quiet();

      write_mode(1'b0);
      queue_random(80);
      wait_quiet();

      // calm stretch with neither side idling
      write_mode(1'b1);
      idle_pct = 0;
      queue_random(80);
      wait_quiet();

      if (expected_bytes.size() != 0)
         report_mismatch($sformatf("%0d bytes never arrived", expected_bytes.size()));
      $display("checked %0d proof bytes from %0d literals, %0d empty clauses, %0d map writes",
               n_bytes, n_lit, n_empty, n_map);
      $display("%0d ignored commands, %0d mode writes, binary and text lines", n_nop, n_mode);
      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
